/* rtl/core/pcr_pkg.sv */
// pcr_pkg: shared types and constants for the pulse capture and replay block
// used by pcr_seg_store and pulse_capture_and_replay; no dependencies
`timescale 1ns / 1ps
package pcr_pkg;

   localparam int DEPTH      = 256;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int IDX_BITS   = ADDR_BITS + 1;
   localparam int COUNT_BITS = 20;
   localparam int TIMER_BITS = 22;
   localparam int CSR_BITS   = 22;

   localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
   localparam logic [IDX_BITS-1:0]   DEPTH_IDX = IDX_BITS'(DEPTH);

   // phase codes
   localparam logic [1:0] PH_RECORD = 2'd0;
   localparam logic [1:0] PH_GAP    = 2'd1;
   localparam logic [1:0] PH_PLAY   = 2'd2;
   localparam logic [1:0] PH_REST   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_LIMIT  = 2'd1;
   localparam logic [1:0] REG_GAP    = 2'd2;
   localparam logic [1:0] REG_REST   = 2'd3;

   localparam logic [19:0] WINDOW_RESET = 20'd1000000;
   localparam logic [8:0]  LIMIT_RESET  = 9'd150;
   localparam logic [21:0] GAP_RESET    = 22'd3000000;
   localparam logic [21:0] REST_RESET   = 22'd2000000;

   typedef struct packed {
      logic [COUNT_BITS-1:0] len;
      logic                  lvl;
   } seg_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      seg_type              data;
   } seg_wr_type;

endpackage

/* rtl/core/pcr_seg_store.sv */
// pcr_seg_store: segment memory, one write port, one registered read port
// a write to the address being read is forwarded; depends on pcr_pkg
`timescale 1ns / 1ps
module pcr_seg_store
   import pcr_pkg::*;
(
   input  logic                 clock,
   input  seg_wr_type           wr,
   input  logic [ADDR_BITS-1:0] raddr,
   output seg_type              rdata
);

   seg_type mem [DEPTH];
   seg_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.addr == raddr) begin
         rd_ff <= wr.data;
      end else begin
         rd_ff <= mem[raddr];
      end
   end

   assign rdata = rd_ff;

endmodule

/* rtl/core/pulse_capture_and_replay.sv */
// pulse_capture_and_replay: records pulse durations of a sampled level and
// replays them; depends on pcr_pkg and pcr_seg_store
`timescale 1ns / 1ps
//
// Usage
//   req_*: one beat per sample tick, req_tdata[0] is the sampled level.
//   rsp_*: one beat per request beat, showing pin_out, phase and
//          captured_count as they stood before that tick was applied.
//   csr_*: register writes, always ready, index 0..3 (window, limit, gap,
//          rest); write only while no result is outstanding.
// Results: each result is registered in the output register or the skid entry.
// Throughput: one tick per cycle while req_tready is high; the state update
//   for a tick is a single registered step, and the next segment of playback
//   is prefetched from segment memory so back-to-back short segments keep pace.
// Stall: results go to an output register backed by one skid entry; a
//   second unread result drops req_tready until rsp_tready returns.
// Reset: registers take their reset values, phase is record, first tick
//   pending. The segment memory is not cleared; playback only reads entries
//   written by the recording just before it.
//
module pulse_capture_and_replay
   import pcr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [0] pin_level, [7:1] zero
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // [0] pin_out, [2:1] phase,
                                            // [11:3] captured_count, [15:12] zero
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_data
);

   // configuration
   logic [19:0] window_ff;
   logic [8:0]  limit_ff;
   logic [21:0] gap_ff;
   logic [21:0] rest_ff;

   // core state
   logic [1:0]            mode_ff, mode_in;
   logic                  first_ff, first_in;
   logic                  held_ff, held_in;
   logic [COUNT_BITS-1:0] since_ff, since_in;
   logic [IDX_BITS-1:0]   count_ff, count_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [COUNT_BITS-1:0] remain_ff, remain_in;
   logic                  cur_lvl_ff, cur_lvl_in;
   seg_type               head_ff, head_in;

   // output stage
   logic        out_valid_ff, skid_valid_ff;
   logic [11:0] out_data_ff, skid_data_ff;

   logic                  accept, pop, pin;
   logic [IDX_BITS-1:0]   lim;
   logic [COUNT_BITS-1:0] elapsed;
   logic [TIMER_BITS-1:0] tick_next;
   logic                  enter_gap, enter_play, enter_rest, enter_record;
   seg_wr_type            wr;
   seg_type               rd;
   logic [ADDR_BITS-1:0]  raddr;
   logic [11:0]           result;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign pin        = req_tdata[0];
   assign csr_ready  = 1'b1;

   assign lim       = (IDX_BITS'(limit_ff) < DEPTH_IDX) ? IDX_BITS'(limit_ff) : DEPTH_IDX;
   assign elapsed   = (since_ff != CNT_MAX) ? since_ff + 1'b1 : CNT_MAX;
   assign tick_next = timer_ff + 1'b1;

   assign result = {count_ff, mode_ff, (mode_ff == PH_PLAY) ? cur_lvl_ff : 1'b0};

   always_comb begin
      mode_in      = mode_ff;
      first_in     = first_ff;
      held_in      = held_ff;
      since_in     = since_ff;
      count_in     = count_ff;
      timer_in     = timer_ff;
      idx_in       = idx_ff;
      remain_in    = remain_ff;
      cur_lvl_in   = cur_lvl_ff;
      head_in      = head_ff;
      wr           = '0;
      enter_gap    = 1'b0;
      enter_play   = 1'b0;
      enter_rest   = 1'b0;
      enter_record = 1'b0;

      if (accept) begin
         case (mode_ff)
            PH_RECORD: begin
               if (first_ff) begin
                  first_in = 1'b0;
                  held_in  = pin;
                  since_in = '0;
                  count_in = '0;
                  if (window_ff == '0 || lim == '0) begin
                     enter_gap = 1'b1;
                  end
               end else if (elapsed >= window_ff || count_ff >= lim) begin
                  enter_gap = 1'b1;
               end else if (pin != held_ff) begin
                  wr.en       = 1'b1;
                  wr.addr     = count_ff[ADDR_BITS-1:0];
                  wr.data.len = elapsed;
                  wr.data.lvl = held_ff;
                  if (count_ff == '0) begin
                     head_in = wr.data;
                  end
                  count_in = count_ff + 1'b1;
                  held_in  = pin;
                  since_in = '0;
                  if (count_in >= lim) begin
                     enter_gap = 1'b1;
                  end
               end else begin
                  since_in = elapsed;
               end
            end
            PH_GAP: begin
               timer_in = tick_next;
               if (tick_next >= gap_ff) begin
                  enter_play = 1'b1;
               end
            end
            PH_PLAY: begin
               if (remain_ff > COUNT_BITS'(1)) begin
                  remain_in = remain_ff - 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  if (idx_in < count_ff) begin
                     remain_in  = rd.len;
                     cur_lvl_in = rd.lvl;
                  end else begin
                     enter_rest = 1'b1;
                  end
               end
            end
            default: begin
               timer_in = tick_next;
               if (tick_next >= rest_ff) begin
                  enter_record = 1'b1;
               end
            end
         endcase

         if (enter_gap) begin
            timer_in = '0;
            if (gap_ff == '0) begin
               enter_play = 1'b1;
            end else begin
               mode_in = PH_GAP;
            end
         end
         if (enter_play) begin
            mode_in   = PH_PLAY;
            idx_in    = '0;
            remain_in = '0;
            if (count_in != '0) begin
               remain_in  = head_in.len;
               cur_lvl_in = head_in.lvl;
            end else begin
               enter_rest = 1'b1;
            end
         end
         if (enter_rest) begin
            timer_in = '0;
            if (rest_ff == '0) begin
               enter_record = 1'b1;
            end else begin
               mode_in = PH_REST;
            end
         end
         if (enter_record) begin
            mode_in  = PH_RECORD;
            first_in = 1'b1;
         end
      end
   end

   // prefetch the entry after the one being played
   assign raddr = ADDR_BITS'(idx_in + 1'b1);

   pcr_seg_store u_store (
      .clock (clock),
      .wr    (wr),
      .raddr (raddr),
      .rdata (rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         limit_ff  <= LIMIT_RESET;
         gap_ff    <= GAP_RESET;
         rest_ff   <= REST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WINDOW: window_ff <= csr_data[19:0];
            REG_LIMIT:  limit_ff  <= csr_data[8:0];
            REG_GAP:    gap_ff    <= csr_data[21:0];
            REG_REST:   rest_ff   <= csr_data[21:0];
            default:    window_ff <= window_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= PH_RECORD;
         first_ff   <= 1'b1;
         held_ff    <= 1'b0;
         since_ff   <= '0;
         count_ff   <= '0;
         timer_ff   <= '0;
         idx_ff     <= '0;
         remain_ff  <= '0;
         cur_lvl_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         first_ff   <= first_in;
         held_ff    <= held_in;
         since_ff   <= since_in;
         count_ff   <= count_in;
         timer_ff   <= timer_in;
         idx_ff     <= idx_in;
         remain_ff  <= remain_in;
         cur_lvl_ff <= cur_lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else if (!accept) begin
            out_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (accept) begin
            out_data_ff <= result;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_data_ff};

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_IDX)
      else $error("segment count beyond memory depth");

   a_play_index: assert property (@(posedge clock) disable iff (reset)
      mode_ff == PH_PLAY |-> idx_ff < count_ff)
      else $error("playback index past recorded segments");

   a_pin_low_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:1] != PH_PLAY |-> !rsp_tdata[0])
      else $error("output driven outside playback");

endmodule
